[design/pvs_pkg.sv]
// ============================================================================
// pvs_pkg
// Shared types, register map and helpers for the perspective vertex setup.
// ============================================================================
package pvs_pkg;

    localparam int DIV_STEPS = 33;

    typedef enum logic [2:0] {
        REG_LIGHT_MODE   = 3'd0,
        REG_VALPHA_ON    = 3'd1,
        REG_TEXTURE_MODE = 3'd2,
        REG_FLAT_RGB     = 3'd3,
        REG_ALPHA_SCALE  = 3'd4,
        REG_DEPTH_BIAS   = 3'd5,
        REG_OVL_X_SCALE  = 3'd6,
        REG_OVL_Y_SCALE  = 3'd7
    } t_reg;

    localparam logic [1:0] LM_NONE = 2'd0;
    localparam logic [1:0] LM_FLAT = 2'd1;
    localparam logic [1:0] LM_MONO = 2'd2;
    localparam logic [1:0] LM_RGB  = 2'd3;

    localparam logic [1:0] TM_NONE    = 2'd0;
    localparam logic [1:0] TM_TEXTURE = 2'd1;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
        logic [31:0] umag;
        logic [31:0] vmag;
        logic        uneg;
        logic        vneg;
        logic [45:0] sumag;
        logic [45:0] svmag;
        logic        suneg;
        logic        svneg;
    } t_pay;

    typedef struct packed {
        logic [32:0] ud;
        logic [32:0] rem;
        logic [32:0] q;
        logic        neg;
        logic        dz;
    } t_div;

    function automatic logic [31:0] sat_mag(input logic [61:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (mag > 62'h80000000) res = 32'h80000000;
            else res = 32'd0 - mag[31:0];
        end else begin
            if (mag > 62'h7FFFFFFF) res = 32'h7FFFFFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction

endpackage

[design/perspective_vertex_setup.sv]
// ============================================================================
// perspective_vertex_setup
// Vertex setup: depth reciprocal, color/alpha choice, perspective texcoords.
// ============================================================================
// Usage:
//   Requests enter on start with all i_* vertex fields; busy is tied low, so a
//   request is taken on every cycle start is high. One result per request
//   appears on the o_out_* ports for one cycle, flagged by o_result_valid.
//   The result is registered at every stage and nothing stalls, so one request
//   per clock is sustained. The pipeline is the reciprocal, a restoring divider
//   with one quotient bit per stage (33 stages), plus entry, setup, w-saturation,
//   multiply and output stages.
//   Configuration goes through the APB-style port (register i at byte 4*i);
//   write it only while no request is in flight.
//   Synchronous reset (i_rst_n low) empties the pipeline and loads register
//   defaults. The receiver cannot stall; results are never held back.
// ============================================================================
module perspective_vertex_setup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_screen_x,
    input  logic signed [31:0] i_screen_y,
    input  logic signed [31:0] i_view_depth,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic signed [31:0] i_overlay_u,
    input  logic signed [31:0] i_overlay_v,
    input  logic [15:0]        i_light_level,
    input  logic [15:0]        i_light_red,
    input  logic [15:0]        i_light_green,
    input  logic [15:0]        i_light_blue,
    input  logic [15:0]        i_vertex_alpha,
    output logic               o_result_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [16:0]        o_out_depth,
    output logic [15:0]        o_out_red,
    output logic [15:0]        o_out_green,
    output logic [15:0]        o_out_blue,
    output logic [15:0]        o_out_alpha,
    output logic signed [31:0] o_out_s,
    output logic signed [31:0] o_out_t,
    output logic signed [31:0] o_out_w,
    output logic signed [31:0] o_out_s2,
    output logic signed [31:0] o_out_t2
);

    localparam int NS = pvs_pkg::DIV_STEPS;

    // config registers
    logic [1:0]  r_light_mode;
    logic        r_valpha_on;
    logic [1:0]  r_texture_mode;
    logic [23:0] r_flat_rgb;
    logic [15:0] r_alpha_scale;
    logic [31:0] r_depth_bias;
    logic [30:0] r_ovl_x_scale;
    logic [30:0] r_ovl_y_scale;

    logic       cfg_wr;
    pvs_pkg::t_reg cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = pvs_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_mode   <= pvs_pkg::LM_NONE;
            r_valpha_on    <= 1'b0;
            r_texture_mode <= pvs_pkg::TM_NONE;
            r_flat_rgb     <= 24'hFFFFFF;
            r_alpha_scale  <= 16'd256;
            r_depth_bias   <= 32'd0;
            r_ovl_x_scale  <= 31'd65536;
            r_ovl_y_scale  <= 31'd65536;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pvs_pkg::REG_LIGHT_MODE:   r_light_mode   <= pwdata[1:0];
                pvs_pkg::REG_VALPHA_ON:    r_valpha_on    <= pwdata[0];
                pvs_pkg::REG_TEXTURE_MODE: r_texture_mode <= pwdata[1:0];
                pvs_pkg::REG_FLAT_RGB:     r_flat_rgb     <= pwdata[23:0];
                pvs_pkg::REG_ALPHA_SCALE:  r_alpha_scale  <= pwdata[15:0];
                pvs_pkg::REG_DEPTH_BIAS:   r_depth_bias   <= pwdata;
                pvs_pkg::REG_OVL_X_SCALE:  r_ovl_x_scale  <= pwdata[30:0];
                pvs_pkg::REG_OVL_Y_SCALE:  r_ovl_y_scale  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pvs_pkg::REG_LIGHT_MODE:   prdata = {30'd0, r_light_mode};
            pvs_pkg::REG_VALPHA_ON:    prdata = {31'd0, r_valpha_on};
            pvs_pkg::REG_TEXTURE_MODE: prdata = {30'd0, r_texture_mode};
            pvs_pkg::REG_FLAT_RGB:     prdata = {8'd0, r_flat_rgb};
            pvs_pkg::REG_ALPHA_SCALE:  prdata = {16'd0, r_alpha_scale};
            pvs_pkg::REG_DEPTH_BIAS:   prdata = r_depth_bias;
            pvs_pkg::REG_OVL_X_SCALE:  prdata = {1'b0, r_ovl_x_scale};
            pvs_pkg::REG_OVL_Y_SCALE:  prdata = {1'b0, r_ovl_y_scale};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- stage 0: bias add, magnitudes ----------------
    logic        r_s0_vld;
    logic [32:0] r_s0_d;
    logic [31:0] r_s0_x, r_s0_y;
    logic [31:0] r_s0_umag, r_s0_vmag, r_s0_u2mag, r_s0_v2mag;
    logic        r_s0_uneg, r_s0_vneg, r_s0_u2neg, r_s0_v2neg;
    logic [15:0] r_s0_lvl, r_s0_red, r_s0_grn, r_s0_blu, r_s0_va;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_vld <= 1'b0;
        else          r_s0_vld <= start;
    end

    always_ff @(posedge i_clk) begin
        r_s0_d     <= {i_view_depth[31], i_view_depth} + {r_depth_bias[31], r_depth_bias};
        r_s0_x     <= i_screen_x;
        r_s0_y     <= i_screen_y;
        r_s0_uneg  <= i_tex_u[31];
        r_s0_vneg  <= i_tex_v[31];
        r_s0_u2neg <= i_overlay_u[31];
        r_s0_v2neg <= i_overlay_v[31];
        r_s0_umag  <= i_tex_u[31] ? 32'd0 - i_tex_u : i_tex_u;
        r_s0_vmag  <= i_tex_v[31] ? 32'd0 - i_tex_v : i_tex_v;
        r_s0_u2mag <= i_overlay_u[31] ? 32'd0 - i_overlay_u : i_overlay_u;
        r_s0_v2mag <= i_overlay_v[31] ? 32'd0 - i_overlay_v : i_overlay_v;
        r_s0_lvl   <= i_light_level;
        r_s0_red   <= i_light_red;
        r_s0_grn   <= i_light_green;
        r_s0_blu   <= i_light_blue;
        r_s0_va    <= i_vertex_alpha;
    end

    // ---------------- stage 1: divisor, color, alpha, overlay scale ----------------
    logic           r_s1_vld;
    pvs_pkg::t_pay  r_s1_pay;
    pvs_pkg::t_div  r_s1_div;
    pvs_pkg::t_pay  n_s1_pay;
    pvs_pkg::t_div  n_s1_div;
    logic [15:0]    fr, fg, fb;
    logic [23:0]    alpha_raw;
    logic [61:0]    su_full, sv_full;

    always_comb begin
        fr = {r_flat_rgb[23:16], r_flat_rgb[23:16]};
        fg = {r_flat_rgb[15:8],  r_flat_rgb[15:8]};
        fb = {r_flat_rgb[7:0],   r_flat_rgb[7:0]};
        n_s1_pay.x = r_s0_x;
        n_s1_pay.y = r_s0_y;
        case (r_light_mode)
            pvs_pkg::LM_FLAT: begin
                n_s1_pay.r = fr; n_s1_pay.g = fg; n_s1_pay.b = fb;
            end
            pvs_pkg::LM_MONO: begin
                n_s1_pay.r = r_s0_lvl; n_s1_pay.g = r_s0_lvl; n_s1_pay.b = r_s0_lvl;
            end
            pvs_pkg::LM_RGB: begin
                n_s1_pay.r = r_s0_red; n_s1_pay.g = r_s0_grn; n_s1_pay.b = r_s0_blu;
            end
            default: begin
                if (r_texture_mode != pvs_pkg::TM_NONE) begin
                    n_s1_pay.r = 16'hFFFF; n_s1_pay.g = 16'hFFFF; n_s1_pay.b = 16'hFFFF;
                end else begin
                    n_s1_pay.r = fr; n_s1_pay.g = fg; n_s1_pay.b = fb;
                end
            end
        endcase
        if (r_valpha_on) alpha_raw = 24'((32'(r_s0_va) * 32'(r_alpha_scale)) >> 8);
        else             alpha_raw = {r_alpha_scale, 8'd0};
        n_s1_pay.a = (alpha_raw > 24'hFFFF) ? 16'hFFFF : alpha_raw[15:0];
        n_s1_pay.umag  = r_s0_umag;
        n_s1_pay.vmag  = r_s0_vmag;
        n_s1_pay.uneg  = r_s0_uneg;
        n_s1_pay.vneg  = r_s0_vneg;
        su_full = 62'(r_s0_u2mag * 63'(r_ovl_x_scale));
        sv_full = 62'(r_s0_v2mag * 63'(r_ovl_y_scale));
        n_s1_pay.sumag = su_full[61:16];
        n_s1_pay.svmag = sv_full[61:16];
        n_s1_pay.suneg = r_s0_u2neg;
        n_s1_pay.svneg = r_s0_v2neg;
        n_s1_div.ud  = r_s0_d[32] ? 33'd0 - r_s0_d : r_s0_d;
        n_s1_div.rem = 33'd0;
        n_s1_div.q   = 33'd0;
        n_s1_div.neg = r_s0_d[32];
        n_s1_div.dz  = (r_s0_d == 33'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else          r_s1_vld <= r_s0_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s1_pay <= n_s1_pay;
        r_s1_div <= n_s1_div;
    end

    // ---------------- divider: 2^32 / ud, one quotient bit per stage ----------------
    logic          r_dv_vld [NS];
    pvs_pkg::t_pay r_dv_pay [NS];
    pvs_pkg::t_div r_dv     [NS];
    pvs_pkg::t_div dv_in    [NS];
    pvs_pkg::t_div n_dv     [NS];
    logic [33:0]   trial    [NS];
    logic          ge       [NS];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            dv_in[k]  = (k == 0) ? r_s1_div : r_dv[(k == 0) ? 0 : k - 1];
            trial[k]  = {dv_in[k].rem, (k == 0)};
            ge[k]     = trial[k] >= {1'b0, dv_in[k].ud};
            n_dv[k]   = dv_in[k];
            n_dv[k].rem = ge[k] ? 33'(trial[k] - {1'b0, dv_in[k].ud}) : trial[k][32:0];
            n_dv[k].q   = {dv_in[k].q[31:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_dv_vld[k] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_s1_vld;
            for (int k = 1; k < NS; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_pay[0] <= r_s1_pay;
        for (int k = 1; k < NS; k++) r_dv_pay[k] <= r_dv_pay[k-1];
        for (int k = 0; k < NS; k++) r_dv[k] <= n_dv[k];
    end

    // ---------------- w stage: sign and saturation ----------------
    logic          r_w_vld;
    pvs_pkg::t_pay r_w_pay;
    logic [31:0]   r_w_uw;
    logic          r_w_neg;
    logic [31:0]   r_w_val;
    logic [31:0]   n_w_uw;
    logic          n_w_neg;
    logic [32:0]   w_lim;

    always_comb begin
        w_lim   = r_dv[NS-1].neg ? 33'h080000000 : 33'h07FFFFFFF;
        n_w_neg = r_dv[NS-1].neg & ~r_dv[NS-1].dz;
        if (r_dv[NS-1].dz)               n_w_uw = 32'h7FFFFFFF;
        else if (r_dv[NS-1].q > w_lim)   n_w_uw = w_lim[31:0];
        else                             n_w_uw = r_dv[NS-1].q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_w_vld <= 1'b0;
        else          r_w_vld <= r_dv_vld[NS-1];
    end

    always_ff @(posedge i_clk) begin
        r_w_pay <= r_dv_pay[NS-1];
        r_w_uw  <= n_w_uw;
        r_w_neg <= n_w_neg;
        r_w_val <= n_w_neg ? 32'd0 - n_w_uw : n_w_uw;
    end

    // ---------------- multiply stage ----------------
    logic          r_m_vld;
    pvs_pkg::t_pay r_m_pay;
    logic          r_m_wneg;
    logic [31:0]   r_m_w;
    logic [16:0]   r_m_dep;
    logic [63:0]   r_m_ps, r_m_pt;
    logic [54:0]   r_m_s2h, r_m_s2l, r_m_t2h, r_m_t2l;
    logic [16:0]   n_m_dep;

    always_comb begin
        if (r_w_val[31] || r_w_val == 32'd0) n_m_dep = 17'h10000;
        else if (r_w_val > 32'h10000)        n_m_dep = 17'd0;
        else                                 n_m_dep = 17'h10000 - r_w_val[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_vld <= 1'b0;
        else          r_m_vld <= r_w_vld;
    end

    always_ff @(posedge i_clk) begin
        r_m_pay  <= r_w_pay;
        r_m_wneg <= r_w_neg;
        r_m_w    <= r_w_val;
        r_m_dep  <= n_m_dep;
        r_m_ps   <= r_w_pay.umag * r_w_uw;
        r_m_pt   <= r_w_pay.vmag * r_w_uw;
        r_m_s2h  <= 55'(r_w_pay.sumag[45:23]) * 55'(r_w_uw);
        r_m_s2l  <= 55'(r_w_pay.sumag[22:0])  * 55'(r_w_uw);
        r_m_t2h  <= 55'(r_w_pay.svmag[45:23]) * 55'(r_w_uw);
        r_m_t2l  <= 55'(r_w_pay.svmag[22:0])  * 55'(r_w_uw);
    end

    // ---------------- output stage ----------------
    logic        r_o_vld;
    logic [31:0] r_o_x, r_o_y, r_o_s, r_o_t, r_o_w, r_o_s2, r_o_t2;
    logic [16:0] r_o_dep;
    logic [15:0] r_o_r, r_o_g, r_o_b, r_o_a;
    logic [77:0] s2_sum, t2_sum;
    logic        textured, overlay;

    always_comb begin
        s2_sum   = {r_m_s2h, 23'd0} + 78'(r_m_s2l);
        t2_sum   = {r_m_t2h, 23'd0} + 78'(r_m_t2l);
        textured = (r_texture_mode != pvs_pkg::TM_NONE);
        overlay  = textured && (r_texture_mode != pvs_pkg::TM_TEXTURE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_m_vld;
    end

    always_ff @(posedge i_clk) begin
        r_o_x   <= r_m_pay.x;
        r_o_y   <= r_m_pay.y;
        r_o_dep <= r_m_dep;
        r_o_r   <= r_m_pay.r;
        r_o_g   <= r_m_pay.g;
        r_o_b   <= r_m_pay.b;
        r_o_a   <= r_m_pay.a;
        r_o_s   <= textured ? pvs_pkg::sat_mag(62'(r_m_ps[63:16]),
                                               r_m_pay.uneg ^ r_m_wneg) : 32'd0;
        r_o_t   <= textured ? pvs_pkg::sat_mag(62'(r_m_pt[63:16]),
                                               r_m_pay.vneg ^ r_m_wneg) : 32'd0;
        r_o_w   <= textured ? r_m_w : 32'd0;
        r_o_s2  <= overlay ? pvs_pkg::sat_mag(s2_sum[77:16],
                                              r_m_pay.suneg ^ r_m_wneg) : 32'd0;
        r_o_t2  <= overlay ? pvs_pkg::sat_mag(t2_sum[77:16],
                                              r_m_pay.svneg ^ r_m_wneg) : 32'd0;
    end

    assign o_result_valid = r_o_vld;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_out_depth    = r_o_dep;
    assign o_out_red      = r_o_r;
    assign o_out_green    = r_o_g;
    assign o_out_blue     = r_o_b;
    assign o_out_alpha    = r_o_a;
    assign o_out_s        = r_o_s;
    assign o_out_t        = r_o_t;
    assign o_out_w        = r_o_w;
    assign o_out_s2       = r_o_s2;
    assign o_out_t2       = r_o_t2;

`ifndef NO_ASSERTIONS
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_out_depth <= 17'h10000)
        else $error("depth out of range");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_vld[NS-1] && r_dv[NS-1].dz) |=> (r_w_uw == 32'h7FFFFFFF && !r_w_neg))
        else $error("zero divisor not saturated");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> ##(pvs_pkg::DIV_STEPS + 3) o_result_valid)
        else $error("request lost in pipeline");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Perspective vertex setup testbench
// Drives vertex requests at random pacing under several register settings,
// predicts each setup vertex in fixed point and checks every result field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 38;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        logic [31:0] sx, sy, z, u, v, u2, v2;
        logic [15:0] lvl, lr, lg, lb, va;
    } t_vert;

    typedef struct {
        logic [31:0] x, y;
        logic [16:0] depth;
        logic [15:0] r, g, b, a;
        logic [31:0] s, t, w, s2, t2;
    } t_setup;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready, start = 0, busy;
    logic [31:0] i_screen_x = 0, i_screen_y = 0, i_view_depth = 0, i_tex_u = 0;
    logic [31:0] i_tex_v = 0, i_overlay_u = 0, i_overlay_v = 0;
    logic [15:0] i_light_level = 0, i_light_red = 0, i_light_green = 0;
    logic [15:0] i_light_blue = 0, i_vertex_alpha = 0;
    logic        o_result_valid;
    logic [31:0] o_out_x, o_out_y, o_out_s, o_out_t, o_out_w, o_out_s2, o_out_t2;
    logic [16:0] o_out_depth;
    logic [15:0] o_out_red, o_out_green, o_out_blue, o_out_alpha;

    perspective_vertex_setup dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // shadow registers
    logic [1:0]  light_mode = pvs_pkg::LM_NONE, tex_mode = pvs_pkg::TM_NONE;
    logic        valpha_on = 0;
    logic [23:0] flat_rgb = 24'hFFFFFF;
    logic [15:0] alpha_scale = 16'd256;
    logic [31:0] depth_bias = 0;
    logic [30:0] ovl_xs = 31'd65536, ovl_ys = 31'd65536;

    t_vert  vert_q[$];
    t_setup setup_q[$];
    int     errors = 0, idle_pct = 0, wdog = 0;
    bit     sent_flag;

    function automatic logic signed [63:0] mul_q16(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [63:0] ua, ub;
        logic [127:0] p;
        logic signed [63:0] r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = ua * ub;
        r = p[79:16];
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic signed [63:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_setup predict_setup(t_vert vi);
        t_setup e;
        logic signed [63:0] d, w, dep, su, sv;
        logic [63:0] ud, q;
        logic [15:0] fr, fg, fb;
        logic [31:0] a;
        d = $signed(vi.z) + $signed(depth_bias);
        if (d == 0) w = 64'sd2147483647;
        else begin
            ud = d < 0 ? -d : d;
            q = 64'h1_0000_0000 / ud;
            w = sat32(d < 0 ? -$signed(q) : $signed(q));
        end
        dep = 64'sd65536 - w;
        if (dep < 0) dep = 0;
        if (dep > 65536) dep = 65536;
        fr = flat_rgb[23:16] * 16'd257;
        fg = flat_rgb[15:8] * 16'd257;
        fb = flat_rgb[7:0] * 16'd257;
        case (light_mode)
            pvs_pkg::LM_FLAT: begin e.r = fr; e.g = fg; e.b = fb; end
            pvs_pkg::LM_MONO: begin e.r = vi.lvl; e.g = vi.lvl; e.b = vi.lvl; end
            pvs_pkg::LM_RGB:  begin e.r = vi.lr; e.g = vi.lg; e.b = vi.lb; end
            default: begin
                if (tex_mode != pvs_pkg::TM_NONE) begin
                    e.r = 16'hFFFF; e.g = 16'hFFFF; e.b = 16'hFFFF;
                end else begin
                    e.r = fr; e.g = fg; e.b = fb;
                end
            end
        endcase
        a = valpha_on ? (32'(vi.va) * alpha_scale) >> 8 : 32'(alpha_scale) << 8;
        e.a = a > 32'hFFFF ? 16'hFFFF : a[15:0];
        e.x = vi.sx;
        e.y = vi.sy;
        e.depth = dep[16:0];
        e.s = 0; e.t = 0; e.w = 0; e.s2 = 0; e.t2 = 0;
        if (tex_mode != pvs_pkg::TM_NONE) begin
            e.s = 32'(sat32(mul_q16($signed(vi.u), w)));
            e.t = 32'(sat32(mul_q16($signed(vi.v), w)));
            e.w = w[31:0];
            if (tex_mode > pvs_pkg::TM_TEXTURE) begin
                su = mul_q16($signed(vi.u2), 64'(ovl_xs));
                sv = mul_q16($signed(vi.v2), 64'(ovl_ys));
                e.s2 = 32'(sat32(mul_q16(su, w)));
                e.t2 = 32'(sat32(mul_q16(sv, w)));
            end
        end
        return e;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", field, got, exp);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_vert vi;
        if (i_rst_n && vert_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            vi = vert_q.pop_front();
            setup_q.push_back(predict_setup(vi));
            start <= 1;
            i_screen_x <= vi.sx; i_screen_y <= vi.sy; i_view_depth <= vi.z;
            i_tex_u <= vi.u; i_tex_v <= vi.v;
            i_overlay_u <= vi.u2; i_overlay_v <= vi.v2;
            i_light_level <= vi.lvl; i_light_red <= vi.lr;
            i_light_green <= vi.lg; i_light_blue <= vi.lb;
            i_vertex_alpha <= vi.va;
        end else begin
            start <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_setup e;
        sent_flag = start && !busy;
        if (i_rst_n && o_result_valid) begin
            if (setup_q.size() == 0) begin
                report_mismatch("unexpected", 0, 0);
            end else begin
                e = setup_q.pop_front();
                if (o_out_x !== e.x) report_mismatch("x", o_out_x, e.x);
                if (o_out_y !== e.y) report_mismatch("y", o_out_y, e.y);
                if (o_out_depth !== e.depth)
                    report_mismatch("depth", 32'(o_out_depth), 32'(e.depth));
                if (o_out_red !== e.r) report_mismatch("red", 32'(o_out_red), 32'(e.r));
                if (o_out_green !== e.g)
                    report_mismatch("green", 32'(o_out_green), 32'(e.g));
                if (o_out_blue !== e.b) report_mismatch("blue", 32'(o_out_blue), 32'(e.b));
                if (o_out_alpha !== e.a)
                    report_mismatch("alpha", 32'(o_out_alpha), 32'(e.a));
                if (o_out_s !== e.s) report_mismatch("s", o_out_s, e.s);
                if (o_out_t !== e.t) report_mismatch("t", o_out_t, e.t);
                if (o_out_w !== e.w) report_mismatch("w", o_out_w, e.w);
                if (o_out_s2 !== e.s2) report_mismatch("s2", o_out_s2, e.s2);
                if (o_out_t2 !== e.t2) report_mismatch("t2", o_out_t2, e.t2);
            end
        end
        if (sent_flag || o_result_valid) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(pvs_pkg::t_reg idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            pvs_pkg::REG_LIGHT_MODE:   light_mode = val[1:0];
            pvs_pkg::REG_VALPHA_ON:    valpha_on = val[0];
            pvs_pkg::REG_TEXTURE_MODE: tex_mode = val[1:0];
            pvs_pkg::REG_FLAT_RGB:     flat_rgb = val[23:0];
            pvs_pkg::REG_ALPHA_SCALE:  alpha_scale = val[15:0];
            pvs_pkg::REG_DEPTH_BIAS:   depth_bias = val;
            pvs_pkg::REG_OVL_X_SCALE:  ovl_xs = val[30:0];
            pvs_pkg::REG_OVL_Y_SCALE:  ovl_ys = val[30:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        while (vert_q.size() != 0 || setup_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return -$urandom_range(0, 32'h0004_0000);
            3: return $urandom_range(0, 32'h0000_0200) - 32'h100;
            4: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    function automatic t_vert random_vertex();
        t_vert vi;
        vi.sx = $urandom; vi.sy = $urandom;
        vi.z = pick_q16(); vi.u = pick_q16(); vi.v = pick_q16();
        vi.u2 = pick_q16(); vi.v2 = pick_q16();
        vi.lvl = 16'($urandom); vi.lr = 16'($urandom); vi.lg = 16'($urandom);
        vi.lb = 16'($urandom); vi.va = 16'($urandom);
        return vi;
    endfunction

    task automatic random_config();
        apb_write(pvs_pkg::REG_LIGHT_MODE, $urandom_range(3));
        apb_write(pvs_pkg::REG_VALPHA_ON, $urandom_range(1));
        apb_write(pvs_pkg::REG_TEXTURE_MODE, $urandom_range(3));
        apb_write(pvs_pkg::REG_FLAT_RGB, $urandom);
        apb_write(pvs_pkg::REG_ALPHA_SCALE,
                  $urandom_range(1) ? $urandom_range(0, 512) : $urandom);
        apb_write(pvs_pkg::REG_DEPTH_BIAS, $urandom_range(1) ? pick_q16() : 0);
        apb_write(pvs_pkg::REG_OVL_X_SCALE, $urandom_range(1) ? $urandom_range(0, 32'h40000)
                                                              : $urandom);
        apb_write(pvs_pkg::REG_OVL_Y_SCALE, $urandom_range(1) ? $urandom_range(0, 32'h40000)
                                                              : $urandom);
    endtask

    initial begin
        t_vert vi;
        int pcts[4] = '{0, 49, 0, 8};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes with overlay on, max alpha and x overlay scales, zero y scale
        apb_write(pvs_pkg::REG_TEXTURE_MODE, 2);
        apb_write(pvs_pkg::REG_VALPHA_ON, 1);
        apb_write(pvs_pkg::REG_ALPHA_SCALE, 16'hFFFF);
        apb_write(pvs_pkg::REG_OVL_X_SCALE, 32'h7FFFFFFF);
        apb_write(pvs_pkg::REG_OVL_Y_SCALE, 0);
        apb_write(pvs_pkg::REG_DEPTH_BIAS, 32'h80000000);
        foreach (pcts[k]) begin
            idle_pct = pcts[k];
            for (int j = 0; j < 6; j++) begin
                vi.sx = j[0] ? 32'h80000000 : 32'h7FFFFFFF;
                vi.sy = j[0] ? 32'h7FFFFFFF : 32'h80000000;
                case (j)
                    0: vi.z = 32'h80000000;       // most negative biased depth
                    1: vi.z = 32'h80000001;       // zero divisor with the max bias
                    2: vi.z = 32'h7FFFFFFF;
                    3: vi.z = 32'h80010000;
                    4: vi.z = 32'h7FFFFFFF;
                    default: vi.z = 32'h80000000 - 1;
                endcase
                vi.u = j[1] ? 32'h80000000 : 32'h7FFFFFFF;
                vi.v = j[1] ? 32'h7FFFFFFF : 32'h80000000;
                vi.u2 = j[0] ? 32'h80000000 : 32'h7FFFFFFF;
                vi.v2 = vi.u2;
                vi.lvl = j[0] ? 16'hFFFF : 16'h0000; vi.lr = vi.lvl; vi.lg = ~vi.lvl;
                vi.lb = vi.lvl; vi.va = j[0] ? 16'hFFFF : 16'h0000;
                vert_q.push_back(vi);
            end
            drain_pipe();
            apb_write(pvs_pkg::REG_LIGHT_MODE, k);
            apb_write(pvs_pkg::REG_TEXTURE_MODE, k == 3 ? 3 : k == 2 ? 0 : 1);
            apb_write(pvs_pkg::REG_DEPTH_BIAS, k == 0 ? 0 : 32'h7FFFFFFF);
            apb_write(pvs_pkg::REG_FLAT_RGB, k[0] ? 24'h000000 : 24'hFF80FF);
            apb_write(pvs_pkg::REG_ALPHA_SCALE, k[0] ? 0 : 16'h0100);
            apb_write(pvs_pkg::REG_VALPHA_ON, k[1]);
            apb_write(pvs_pkg::REG_OVL_X_SCALE, 31'd65536);
            apb_write(pvs_pkg::REG_OVL_Y_SCALE, 32'h7FFFFFFF);
        end

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            drain_pipe();
            random_config();
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 49 : 8;
            for (int n = 0; n < 100; n++) vert_q.push_back(random_vertex());
        end
        drain_pipe();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
